/* hdl/sha256_stream_hasher_assert.svh */
// Assertion macros for the stream hasher.
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

/* hdl/sha_pkg.sv */
package sha_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int LEN_POS = 56;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_OUT
    } state_t;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

/* hdl/sha256_stream_hasher.sv */
// SHA-256 over a byte stream. A request carrying a byte is taken while a block fills; the
// 64th byte of a block starts a compression: a load phase (one byte a cycle from the block
// memory, whose read is registered), the rounds (one round per cycle) and an update step,
// during all of which in_stall is high. At end of message the pad, zero fill and length are
// written into the block memory one byte a cycle from the fill position to the end of the
// block; when an extra block is needed it is written after the first compression. The eight
// digest words are then offered one per cycle while out_stall is low, and the hash returns
// to its initial value.
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

`include "sha256_stream_hasher_assert.svh"

    logic [7:0] block_mem [BLOCK_BYTES];
    logic [7:0] mem_rdata;
    logic [5:0] mem_raddr;
    logic       mem_we;
    logic [5:0] mem_waddr;
    logic [7:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            block_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= block_mem[mem_raddr];
    end

    state_t      state_reg, state_next;
    logic [31:0] hash_reg [8];
    logic [31:0] wk_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] count_reg, count_next;
    logic [6:0]  step_reg, step_next;
    logic        final_reg, final_next;
    logic        two_reg, two_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic [31:0] ld_word_reg;

    logic [63:0] bits;
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1, wnew, wcur;
    logic        round_en, load_en, update_en, hash_init;

    assign bits = {count_reg[60:0], 3'b000};
    assign a = wk_reg[0]; assign b = wk_reg[1]; assign c = wk_reg[2]; assign d = wk_reg[3];
    assign e = wk_reg[4]; assign f = wk_reg[5]; assign g = wk_reg[6]; assign h = wk_reg[7];

    always_comb
    begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = w_reg[0] + s0 + w_reg[9] + s1;
        wcur = (step_reg < 7'd16) ? w_reg[0] : wnew;
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + round_k(step_reg[5:0]) + wcur;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next = fill_reg;
        count_next = count_reg;
        step_next = step_reg;
        final_next = final_reg;
        two_next = two_reg;
        oidx_next = oidx_reg;
        in_stall = 1'b1;
        out_valid = 1'b0;
        mem_we = 1'b0;
        mem_waddr = fill_reg;
        mem_wdata = data_byte;
        mem_raddr = step_reg[5:0];
        round_en = 1'b0;
        load_en = 1'b0;
        update_en = 1'b0;
        hash_init = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (byte_valid)
                    begin
                        mem_we = 1'b1;
                        fill_next = fill_reg + 6'd1;
                        count_next = count_reg + 64'd1;
                    end
                    final_next = end_of_message;
                    if (byte_valid && fill_reg == 6'd63)
                    begin
                        state_next = ST_LOAD;
                        step_next = '0;
                        two_next = end_of_message;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD;
                        step_next = {1'b0, fill_next};
                        two_next = (fill_next > 6'd55);
                    end
                end
            end
            ST_PAD:
            begin
                mem_we = 1'b1;
                mem_waddr = step_reg[5:0];
                if (!two_reg && step_reg[5:0] >= 6'd56)
                begin
                    mem_wdata = bits[8 * (63 - step_reg[5:0]) +: 8];
                end
                else if (step_reg[5:0] == fill_reg)
                begin
                    mem_wdata = PAD_BYTE;
                end
                else
                begin
                    mem_wdata = '0;
                end
                if (step_reg[5:0] == 6'd63)
                begin
                    state_next = ST_LOAD;
                    step_next = '0;
                end
                else
                begin
                    step_next = step_reg + 7'd1;
                end
            end
            ST_LOAD:
            begin
                load_en = 1'b1;
                step_next = step_reg + 7'd1;
                if (step_reg == 7'd64)
                begin
                    state_next = ST_ROUND;
                    step_next = '0;
                end
            end
            ST_ROUND:
            begin
                round_en = 1'b1;
                step_next = step_reg + 7'd1;
                if (step_reg == 7'd63)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                update_en = 1'b1;
                fill_next = '0;
                if (!final_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (two_reg)
                begin
                    two_next = 1'b0;
                    state_next = ST_PAD;
                    step_next = '0;
                    fill_next = (fill_reg == 6'd0) ? 6'd0 : 6'd63;
                end
                else
                begin
                    state_next = ST_OUT;
                    oidx_next = '0;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        hash_init = 1'b1;
                        count_next = '0;
                        fill_next = '0;
                        final_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // When the pad byte already sits in the previous block, fill is parked on the last byte,
    // where the length field takes precedence. After a full final block fill stays at zero,
    // so the pad byte opens the extra block.

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg <= '0;
            count_reg <= '0;
            step_reg <= '0;
            final_reg <= 1'b0;
            two_reg <= 1'b0;
            oidx_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= init_h(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            count_reg <= count_next;
            step_reg <= step_next;
            final_reg <= final_next;
            two_reg <= two_next;
            oidx_reg <= oidx_next;
            if (hash_init)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= init_h(3'(i));
                end
            end
            else if (update_en)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + wk_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en && step_reg != 7'd0)
        begin
            ld_word_reg <= {ld_word_reg[23:0], mem_rdata};
            if (step_reg[1:0] == 2'd0)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i + 1];
                end
                w_reg[15] <= {ld_word_reg[23:0], mem_rdata};
            end
        end
        if (load_en && step_reg == 7'd64)
        begin
            for (int i = 0; i < 8; i++)
            begin
                wk_reg[i] <= hash_reg[i];
            end
        end
        if (round_en)
        begin
            wk_reg[0] <= t1 + t2;
            wk_reg[1] <= a;
            wk_reg[2] <= b;
            wk_reg[3] <= c;
            wk_reg[4] <= d + t1;
            wk_reg[5] <= e;
            wk_reg[6] <= f;
            wk_reg[7] <= g;
            if (step_reg < 7'd16)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i + 1];
                end
                w_reg[15] <= w_reg[0];
            end
            else
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i + 1];
                end
                w_reg[15] <= wnew;
            end
        end
    end

    assign digest_word = hash_reg[oidx_reg];
    assign word_index = oidx_reg;
    assign last_word = (oidx_reg == 3'd7);

    `ASSERT_IMPLIES(a_stall_busy, clk, rst_n, state_reg != ST_IDLE, in_stall)
    `ASSERT_IMPLIES(a_out_only_out, clk, rst_n, out_valid, state_reg == ST_OUT)
    `ASSERT_NEXT(a_last_idle, clk, rst_n, out_valid && !out_stall && last_word,
        state_reg == ST_IDLE && fill_reg == 6'd0)

endmodule

/* tb/tb_sha256_stream_hasher.sv */
module tb_sha256_stream_hasher;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;
    localparam int N_ITEMS = 136;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        end_of_message;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    sha256_stream_hasher u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       eom;
    } request_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_t;

    typedef struct packed {
        request_t    req;
        logic        known;
        logic [31:0] word0;
    } row_t;

    localparam int N_DIRECTED = 9;

    // Directed rows: empty message, "abc" with idle requests, a two-byte message and a
    // byte-free end that hashes the empty message.
    localparam row_t DIRECTED [N_DIRECTED] = '{
        '{'{8'h00, 1'b0, 1'b1}, 1'b1, 32'he3b0c442},
        '{'{8'h61, 1'b1, 1'b0}, 1'b0, 32'h00000000},
        '{'{8'h62, 1'b1, 1'b0}, 1'b0, 32'h00000000},
        '{'{8'h00, 1'b0, 1'b0}, 1'b0, 32'h00000000},
        '{'{8'hff, 1'b0, 1'b0}, 1'b0, 32'h00000000},
        '{'{8'h63, 1'b1, 1'b1}, 1'b1, 32'hba7816bf},
        '{'{8'h00, 1'b1, 1'b0}, 1'b0, 32'h00000000},
        '{'{8'hff, 1'b1, 1'b1}, 1'b0, 32'h00000000},
        '{'{8'haa, 1'b0, 1'b1}, 1'b1, 32'he3b0c442}
    };

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic [31:0] chain [8];
    logic [7:0]  blk [64];
    int          fill;
    logic [63:0] byte_count;

    digest_t     expected_words [$];
    request_t    req_q [$];
    logic [31:0] known_word0 [$];
    logic        known_flag [$];

    int  errors;
    int  digests_seen;
    int  idle_cycles;
    bit  quiet;
    bit  hold_off;
    bit  stim_done;

    function automatic logic [31:0] ror(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
        begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + K_TAB[i] + w[i];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++)
            chain[i] = H_INIT[i];
        fill = 0;
        byte_count = '0;
    endfunction

    function automatic void hash_request(request_t r, bit known, logic [31:0] word0);
        logic [63:0] bits;
        int pos;
        digest_t dw;
        if (r.has_byte)
        begin
            blk[fill] = r.data;
            fill++;
            byte_count++;
            if (fill == 64)
            begin
                compress_block();
                fill = 0;
            end
        end
        if (!r.eom)
            return;
        bits = byte_count << 3;
        pos = fill;
        blk[pos] = 8'h80;
        pos++;
        if (pos > 56)
        begin
            while (pos < 64)
            begin
                blk[pos] = 8'h00;
                pos++;
            end
            compress_block();
            pos = 0;
        end
        while (pos < 56)
        begin
            blk[pos] = 8'h00;
            pos++;
        end
        for (int i = 0; i < 8; i++)
            blk[63-i] = bits[8*i +: 8];
        compress_block();
        if (known && chain[0] != word0)
        begin
            $error("predictor digest_word[0]: expected %h actual %h", word0, chain[0]);
            errors++;
        end
        for (int i = 0; i < 8; i++)
        begin
            dw.word = chain[i];
            dw.index = 3'(i);
            dw.last = (i == 7);
            expected_words.push_back(dw);
        end
        restart_hash();
    endfunction

    function automatic void add_request(logic [7:0] d, bit hb, bit eom, bit known = 0,
                                        logic [31:0] w0 = '0);
        request_t r;
        r.data = d;
        r.has_byte = hb;
        r.eom = eom;
        req_q.push_back(r);
        known_flag.push_back(known);
        known_word0.push_back(w0);
    endfunction

    function automatic void add_message(int len, bit noise);
        for (int i = 0; i < len; i++)
        begin
            if (noise && $urandom_range(0, 9) == 0)
                add_request(8'($urandom), 1'b0, 1'b0);
            add_request(8'($urandom), 1'b1, (i == len - 1) && noise);
        end
        if (!noise || len == 0)
            add_request(8'($urandom), 1'b0, 1'b1);
    endfunction

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Sender: offers requests from the queue, idling now and then.
    initial
    begin
        request_t r;
        in_valid = 1'b0;
        data_byte = '0;
        byte_valid = 1'b0;
        end_of_message = 1'b0;
        rst_n = 1'b0;
        errors = 0;
        digests_seen = 0;
        stim_done = 0;
        restart_hash();
        for (int i = 0; i < 64; i++)
            blk[i] = '0;

        for (int i = 0; i < N_DIRECTED; i++)
            add_request(DIRECTED[i].req.data, DIRECTED[i].req.has_byte, DIRECTED[i].req.eom,
                        DIRECTED[i].known, DIRECTED[i].word0);
        // A 56-byte message needs an extra pad block; a 64-byte one ends on a full block.
        for (int i = 0; i < 56; i++)
            add_request(8'($urandom), 1'b1, i == 55);
        for (int i = 0; i < 64; i++)
            add_request(8'($urandom), 1'b1, i == 63);
        while (req_q.size() < N_ITEMS)
        begin
            case ($urandom_range(0, 2))
                0: add_message($urandom_range(0, 6), $urandom_range(0, 1));
                default: add_request(8'($urandom), $urandom_range(0, 1), $urandom_range(0, 1));
            endcase
        end
        add_request(8'h00, 1'b0, 1'b1);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (req_q.size() > 0)
        begin
            if (!quiet && $urandom_range(0, 99) < 8)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                continue;
            end
            r = req_q[0];
            in_valid <= 1'b1;
            data_byte <= r.data;
            byte_valid <= r.has_byte;
            end_of_message <= r.eom;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            hash_request(r, known_flag[0], known_word0[0]);
            void'(req_q.pop_front());
            void'(known_flag.pop_front());
            void'(known_word0.pop_front());
        end
        in_valid <= 1'b0;
        stim_done = 1;
    end

    // Receiver stall pattern, with one long hold-off and one quiet stretch.
    initial
    begin
        int n;
        n = 0;
        out_stall = 1'b0;
        quiet = 0;
        hold_off = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            n++;
            if (n == 300)
                hold_off = 1;
            if (n == 800)
                hold_off = 0;
            quiet = (n > 900 && n < 1700);
            out_stall <= hold_off || (!quiet && $urandom_range(0, 99) < 8);
        end
    end

    always @(posedge clk)
    begin
        digest_t exp_w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected digest word %h", digest_word);
                errors++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (digest_word !== exp_w.word)
                begin
                    $error("digest_word: expected %h actual %h", exp_w.word, digest_word);
                    errors++;
                end
                if (word_index !== exp_w.index)
                begin
                    $error("word_index: expected %0d actual %0d", exp_w.index, word_index);
                    errors++;
                end
                if (last_word !== exp_w.last)
                begin
                    $error("last_word: expected %0d actual %0d", exp_w.last, last_word);
                    errors++;
                end
                if (exp_w.last)
                    digests_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        @(posedge rst_n);
        wait (stim_done);
        while (expected_words.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Covered %0d digests: empty, short, pad-boundary and full-block messages,",
                 digests_seen);
        $display("with idle requests, random stalls and a long output hold-off.");
        if (errors == 0 && expected_words.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
